/* design/btmx_pkg.sv */
package btmx_pkg;

  // command codes on the input tuser
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // status codes on the output tuser
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SLOT = 2'd2;

  // what a token does as it passes down the level chain
  typedef enum logic [1:0] {
    OP_PROBE  = 2'd0,
    OP_COMMIT = 2'd1,
    OP_DELETE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // token control handed from one level cell to the next
  typedef struct packed {
    logic valid;
    op_t  op;
    logic va;    // index a names a node
    logic vb;    // index b names a node
    logic live;  // walk still on a path
  } ctl_t;

endpackage

/* design/binary_trie_max_xor.sv */
// counted binary trie answering maximum-xor queries over stored keys
// input beats: s_tuser carries the command (insert, delete, query, clear),
// s_tdata carries the key and the slot number that names a stored key
// output beats: one per command, m_tdata holds the query result (zero for
// other commands), m_tuser holds the status (ok, pool full, bad slot)
// the trie is a chain of KEY_BITS+1 level cells, each holding the nodes of one
// depth in its own memory; a token moves one cell per cycle, and a walk is
// launched, passes the chain and is retired before the output register is loaded
// insert and delete read the slot table first; an insert runs a probe walk that
// counts the nodes to create, then a commit walk that writes them; an insert
// refused for a full pool ends after the probe walk, and a command refused for
// its slot ends after the slot table read
// clear and reset sweep the slot table before the next beat is taken; reset
// also empties every level cell at once
// one command is worked at a time; a new beat is taken in the cycle after the
// previous result lands in the output register, and a stalled receiver holds
// that register until the beat is taken
module binary_trie_max_xor import btmx_pkg::*; #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 32768,
  parameter int SLOTS      = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((KEY_BITS + 10 + 7) / 8)*8-1:0] s_tdata,  // key, slot
  input  logic [1:0]                            s_tuser,  // cmd
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((KEY_BITS + 7) / 8)*8-1:0]      m_tdata,  // best
  output logic [1:0]                            m_tuser   // status
);

  localparam int OUT_W = ((KEY_BITS + 7) / 8) * 8;
  localparam int IW    = $clog2(NODE_COUNT);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int MW    = $clog2(KEY_BITS + 1);
  localparam int SAW   = $clog2(SLOTS);
  localparam int SXW   = (SAW > 10) ? SAW : 10;
  localparam int NFW   = $clog2(NODE_COUNT + KEY_BITS + 1);
  localparam int NC    = KEY_BITS + 1;  // level cells, root to leaf

  typedef enum logic [5:0] {
    S_SWEEP = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SLOT  = 6'b000100,
    S_CHECK = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state;
  logic [1:0]          cmd_r, status_r;
  logic [KEY_BITS-1:0] walk_key, best_w;
  logic [9:0]          slot_r;
  logic [SXW-1:0]      slot_x;
  logic [SAW-1:0]      slot_a, sweep, sm_wa;
  logic [KEY_BITS:0]   slot_mem [SLOTS];  // {used, key}
  logic [KEY_BITS:0]   slot_rd, sm_wd;
  logic                sm_we, in_range, launch, clr_pend, clr;
  op_t                 op_r;
  logic [NFW-1:0]      next_free;

  // chain wiring, element g feeds cell g
  ctl_t                ctl  [NC+1];
  logic [IW-1:0]       ia   [NC+1];
  logic [IW-1:0]       ib   [NC+1];
  logic [MW-1:0]       miss [NC+1];
  logic [IW-1:0]       fill [NC+1];
  logic                res  [NC];

  assign s_tready = (state == S_IDLE);
  assign clr      = (state == S_IDLE) && s_tvalid && (s_tuser == CMD_CLEAR);
  assign slot_x   = SXW'(slot_r);
  assign slot_a   = slot_x[SAW-1:0];
  assign in_range = 32'(slot_r) < 32'(SLOTS);

  // token entering the root cell
  assign ctl[0]  = '{valid: launch, op: op_r, va: 1'b1, vb: 1'b0, live: 1'b1};
  assign ia[0]   = '0;
  assign ib[0]   = '0;
  assign miss[0] = '0;
  assign fill[NC] = '0;

  for (genvar g = 0; g < NC; g++) begin : g_lvl
    localparam int DEP = (g >= IW) ? NODE_COUNT : ((g < 1) ? 2 : (1 << g));
    logic kb, db;
    if (g < KEY_BITS) begin : g_kb
      assign kb = walk_key[KEY_BITS-1-g];
    end else begin : g_kb0
      assign kb = 1'b0;
    end
    if (g >= 1) begin : g_db
      assign db = walk_key[KEY_BITS-g];
      // each level below the root settles one bit of the query result
      assign best_w[KEY_BITS-g] = res[g];
    end else begin : g_db0
      assign db = 1'b0;
    end
    btmx_cell #(
      .LEVEL(g), .KEY_BITS(KEY_BITS), .IW(IW), .DEPTH(DEP), .CW(CW), .MW(MW)
    ) u_cell (
      .clk(clk), .rst(rst), .clr(clr),
      .key_bit(kb), .dec_bit(db),
      .in_ctl(ctl[g]), .in_ia(ia[g]), .in_ib(ib[g]), .in_miss(miss[g]),
      .child_fill(fill[g+1]),
      .out_ctl(ctl[g+1]), .out_ia(ia[g+1]), .out_ib(ib[g+1]), .out_miss(miss[g+1]),
      .fill_out(fill[g]), .res_bit(res[g])
    );
  end

  // slot table write port: sweep, insert done, delete done
  always_comb begin
    sm_we = 1'b0;
    sm_wa = slot_a;
    sm_wd = {1'b1, walk_key};
    if (state == S_SWEEP) begin
      sm_we = 1'b1;
      sm_wa = sweep;
      sm_wd = '0;
    end else if (state == S_WALK && ctl[NC].valid) begin
      if (op_r == OP_COMMIT) begin
        sm_we = 1'b1;
      end else if (op_r == OP_DELETE) begin
        sm_we = 1'b1;
        sm_wd = {1'b0, walk_key};
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_rd <= slot_mem[slot_a];
    if (sm_we) begin
      slot_mem[sm_wa] <= sm_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep     <= '0;
      clr_pend  <= 1'b0;
      launch    <= 1'b0;
      next_free <= NFW'(1);
      m_tvalid  <= 1'b0;
    end else begin
      launch <= 1'b0;
      // in S_DONE the output register is reloaded below instead
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == SAW'(SLOTS - 1)) begin
            sweep    <= '0;
            clr_pend <= 1'b0;
            state    <= clr_pend ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r    <= s_tuser;
            walk_key <= s_tdata[KEY_BITS-1:0];
            slot_r   <= s_tdata[KEY_BITS+9:KEY_BITS];
            status_r <= ST_OK;
            case (s_tuser)
              CMD_INSERT, CMD_DELETE: begin
                state <= S_SLOT;
              end
              CMD_QUERY: begin
                op_r   <= OP_QUERY;
                launch <= 1'b1;
                state  <= S_WALK;
              end
              default: begin
                next_free <= NFW'(1);
                clr_pend  <= 1'b1;
                state     <= S_SWEEP;
              end
            endcase
          end
        end
        S_SLOT: begin
          state <= S_CHECK;  // slot table read in flight
        end
        S_CHECK: begin
          if (!in_range || (slot_rd[KEY_BITS] == (cmd_r == CMD_INSERT))) begin
            status_r <= ST_SLOT;
            state    <= S_DONE;
          end else begin
            if (cmd_r == CMD_INSERT) begin
              op_r <= OP_PROBE;
            end else begin
              op_r     <= OP_DELETE;
              walk_key <= slot_rd[KEY_BITS-1:0];
            end
            launch <= 1'b1;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (ctl[NC].valid) begin
            if (op_r == OP_PROBE) begin
              // refuse the insert if the new nodes would not fit
              if (next_free + NFW'(miss[NC]) > NFW'(NODE_COUNT)) begin
                status_r <= ST_FULL;
                state    <= S_DONE;
              end else begin
                next_free <= next_free + NFW'(miss[NC]);
                op_r      <= OP_COMMIT;
                launch    <= 1'b1;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= (cmd_r == CMD_QUERY) ? OUT_W'(best_w) : '0;
            m_tuser  <= status_r;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a token only reaches the leaf end while a walk is outstanding
  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    ctl[NC].valid |-> state == S_WALK)
    else $error("token left the chain outside a walk");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while a command is in work");

  // node pool never overcommitted
  a_pool: assert property (@(posedge clk) disable iff (rst)
    next_free <= NFW'(NODE_COUNT))
    else $error("node pool overcommitted");

  // a launch never meets a token still in the chain tail
  a_launch: assert property (@(posedge clk) disable iff (rst)
    launch |-> !ctl[NC].valid)
    else $error("walk launched while another is finishing");

endmodule

/* design/btmx_cell.sv */
module btmx_cell import btmx_pkg::*; #(
  parameter int LEVEL    = 0,
  parameter int KEY_BITS = 31,
  parameter int IW       = 15,
  parameter int DEPTH    = 2,
  parameter int CW       = 11,
  parameter int MW       = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          key_bit,
  input  logic          dec_bit,
  input  ctl_t          in_ctl,
  input  logic [IW-1:0] in_ia,
  input  logic [IW-1:0] in_ib,
  input  logic [MW-1:0] in_miss,
  input  logic [IW-1:0] child_fill,
  output ctl_t          out_ctl,
  output logic [IW-1:0] out_ia,
  output logic [IW-1:0] out_ib,
  output logic [MW-1:0] out_miss,
  output logic [IW-1:0] fill_out,
  output logic          res_bit
);

  localparam int AW   = $clog2(DEPTH);
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int EW   = 2 * IW + 2 + CW;
  localparam int XW   = IW + 1;
  localparam bit LEAF = (LEVEL == KEY_BITS);

  // entry: {v1, c1, v0, c0, cnt}
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_a, rd_b, ea, eb, cur, wdata;
  ctl_t          st;
  logic [IW-1:0] st_ia, st_ib;
  logic [MW-1:0] st_miss;
  logic [FW-1:0] fill;

  logic          pick_alt, pick_same, cur_live, wen;
  logic [CW-1:0] cnt, cnt_a, cnt_b;
  logic [IW-1:0] c0, c1, ch, oth;
  logic          v0, v1, chv, othv;

  always_ff @(posedge clk) begin
    rd_a    <= mem[in_ia[AW-1:0]];
    rd_b    <= mem[in_ib[AW-1:0]];
    st_ia   <= in_ia;
    st_ib   <= in_ib;
    st_miss <= in_miss;
    if (wen) begin
      mem[st_ia[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      fill <= '0;
    end else if (wen && st.op == OP_COMMIT && XW'(st_ia) == XW'(fill)) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st.valid && st.op == OP_QUERY) begin
      res_bit <= cur_live ? pick_alt : dec_bit;
    end
  end

  always_comb begin
    // entries past the fill count were never written since the last clear
    ea    = (XW'(st_ia) >= XW'(fill)) ? '0 : rd_a;
    eb    = (XW'(st_ib) >= XW'(fill)) ? '0 : rd_b;
    cnt_a = ea[CW-1:0];
    cnt_b = eb[CW-1:0];
    pick_alt  = st.va && (cnt_a != '0);
    pick_same = st.vb && (cnt_b != '0);
    if (LEVEL != 0 && st.op == OP_QUERY) begin
      cur      = pick_alt ? ea : eb;
      cur_live = st.live && (pick_alt || pick_same);
    end else begin
      cur      = ea;
      cur_live = st.live;
    end
    cnt  = cur[CW-1:0];
    c0   = cur[CW+IW-1:CW];
    v0   = cur[CW+IW];
    c1   = cur[CW+2*IW:CW+IW+1];
    v1   = cur[EW-1];
    ch   = key_bit ? c1 : c0;
    oth  = key_bit ? c0 : c1;
    chv  = LEAF ? 1'b0 : (key_bit ? v1 : v0);
    othv = LEAF ? 1'b0 : (key_bit ? v0 : v1);

    out_ctl  = st;
    out_ia   = ch;
    out_ib   = '0;
    out_miss = st_miss;
    wen      = 1'b0;
    wdata    = cur;

    case (st.op)
      OP_PROBE: begin
        out_ctl.live = cur_live && chv;
        if (cur_live && !chv && !LEAF) begin
          out_miss = MW'(KEY_BITS - LEVEL);
        end
      end
      OP_COMMIT: begin
        wen = st.valid && cur_live;
        wdata[CW-1:0] = cnt + 1'b1;
        if (!LEAF && !chv) begin
          if (key_bit) begin
            wdata[CW+2*IW:CW+IW+1] = child_fill;
            wdata[EW-1]            = 1'b1;
          end else begin
            wdata[CW+IW-1:CW] = child_fill;
            wdata[CW+IW]      = 1'b1;
          end
        end
        out_ia       = chv ? ch : child_fill;
        out_ctl.live = cur_live;
      end
      OP_DELETE: begin
        wen = st.valid && cur_live;
        if (cnt != '0) begin
          wdata[CW-1:0] = cnt - 1'b1;
        end
        out_ctl.live = cur_live && chv;
      end
      OP_QUERY: begin
        out_ia       = oth;
        out_ib       = ch;
        out_ctl.va   = cur_live && othv;
        out_ctl.vb   = cur_live && chv;
        out_ctl.live = cur_live;
      end
      default: begin
        out_ctl.live = 1'b0;
      end
    endcase
  end

  assign fill_out = IW'(fill);

endmodule
